// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the parser modules.
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/vsp_pkg.sv =====
package vsp_pkg;

  // Item queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_NAME_LEN = 2'd0;
  localparam logic [1:0] REG_MAX_ID_COUNT = 2'd1;
  localparam logic [1:0] REG_MAX_ID_LEN   = 2'd2;

  localparam logic [15:0] RST_MAX_NAME_LEN = 16'd128;
  localparam logic [7:0]  RST_MAX_ID_COUNT = 8'd64;
  localparam logic [15:0] RST_MAX_ID_LEN   = 16'd1024;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_ID      = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_STATUS   = 3'd1;
  localparam logic [2:0] ERR_NAME     = 3'd2;
  localparam logic [2:0] ERR_COUNT    = 3'd3;
  localparam logic [2:0] ERR_ID       = 3'd4;
  localparam logic [2:0] ERR_TRAILING = 3'd5;
  localparam logic [2:0] ERR_TRUNC    = 3'd6;

  localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

  typedef struct packed {
    logic [15:0] max_name_len;
    logic [7:0]  max_id_count;
    logic [15:0] max_id_len;
  } vsp_cfg_t;

  // One classified input item
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
    logic       trunc;
  } vsp_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  id_index;
    logic [30:0] status_value;
    logic [7:0]  id_total;
    logic [2:0]  error_code;
    logic        complete;
  } vsp_result_t;

endpackage

// ===== hw/rtl/varint_string_response_parser_unit.sv =====
// Response message parser. Feed a message one byte per item on in_* with
// in_tlast low; close it with one item that has in_tlast high (its data is
// ignored, in_tuser flags a cut-short capture). Every item yields exactly one
// result on out_*: kind 0 for a header byte consumed or a byte ignored after
// an error, kind 1 for a status name byte, kind 2 for an identifier byte
// (with its index), and kind 3 for the verdict carrying the decoded status,
// identifier count, first error code and the complete flag. After a verdict
// the parser starts over; limits written through cfg_* persist. The block
// takes one item per clock cycle while out_tready is high: a two-entry
// input queue feeds the parser, whose state update writes an output
// register, so each accepted item passes the queue and then the output
// register before its result shows on out_tvalid and is held until taken.
// in_tready only drops when the queue fills because out_tready is held low.
// The cfg port always accepts; write it only while no message is in flight.
module varint_string_response_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // action: high on the end-of-message item
  input  logic        in_tuser,    // [0] truncated
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [7:0] out_byte, [15:8] id_index,
                                   // [46:16] status_value, [54:47] id_total,
                                   // [57:55] error_code, [58] complete, zero pad
  output logic [1:0]  out_tuser,   // [1:0] kind
  // Limit registers
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import vsp_pkg::*;

  vsp_cfg_t    cfg_r;
  logic        q_valid;
  vsp_item_t   q_item;
  logic        q_pop;
  vsp_result_t res;

  // Limits: always ready, unknown index dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_name_len <= RST_MAX_NAME_LEN;
      cfg_r.max_id_count <= RST_MAX_ID_COUNT;
      cfg_r.max_id_len   <= RST_MAX_ID_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_NAME_LEN: cfg_r.max_name_len <= cfg_data;
        REG_MAX_ID_COUNT: cfg_r.max_id_count <= cfg_data[7:0];
        REG_MAX_ID_LEN:   cfg_r.max_id_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: accept and classify items into the queue
  vsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Back: run the parser and hold each result until taken
  vsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  // Pack result fields, lowest first
  assign out_tuser = res.kind;
  assign out_tdata = {5'd0, res.complete, res.error_code, res.id_total,
                      res.status_value, res.id_index, res.out_byte};

endmodule

// ===== hw/rtl/vsp_front.sv =====
`include "assert_macros.svh"

module vsp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] data_byte
  input  logic               in_tlast,   // action: end of message
  input  logic               in_tuser,   // [0] truncated
  output logic               q_valid,
  output vsp_pkg::vsp_item_t q_item,
  input  logic               q_pop
);
  import vsp_pkg::*;

  vsp_item_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_r;
  logic [QPTR_W-1:0]  rd_r;
  logic [QCNT_W-1:0]  cnt_r;
  vsp_item_t          entry;
  logic               push;

  // Classify: the truncated flag only matters on an end item
  always_comb begin
    entry.is_end = in_tlast;
    entry.data   = in_tdata;
    entry.trunc  = in_tuser & in_tlast;
  end

  assign in_tready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (q_pop) rd_r <= rd_r + 1'b1;
      if (push && !q_pop) cnt_r <= cnt_r + 1'b1;
      else if (q_pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= entry;
  end

  `VSP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
  `VSP_ASSERT_NOW(a_no_pop_empty, q_pop, cnt_r != '0, "back popped an empty queue")
  `VSP_ASSERT_NEXT(a_head_bypass, push && cnt_r == '0, q_item == $past(entry), "head lost item")

endmodule

// ===== hw/rtl/vsp_back.sv =====
`include "assert_macros.svh"

module vsp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vsp_pkg::vsp_cfg_t    cfg,
  input  logic                 q_valid,
  input  vsp_pkg::vsp_item_t   q_item,
  output logic                 q_pop,
  output logic                 res_valid,
  output vsp_pkg::vsp_result_t res,
  input  logic                 res_ready
);
  import vsp_pkg::*;

  localparam logic [2:0] PH_STATUS     = 3'd0;
  localparam logic [2:0] PH_NAME_LEN   = 3'd1;
  localparam logic [2:0] PH_NAME       = 3'd2;
  localparam logic [2:0] PH_AFTER_NAME = 3'd3;
  localparam logic [2:0] PH_COUNT      = 3'd4;
  localparam logic [2:0] PH_ID_LEN     = 3'd5;
  localparam logic [2:0] PH_ID         = 3'd6;
  localparam logic [2:0] PH_DONE       = 3'd7;

  logic [2:0]  phase_r,   phase_nxt;
  logic [31:0] vval_r,    vval_nxt;
  logic [2:0]  vcnt_r,    vcnt_nxt;
  logic [15:0] left_r,    left_nxt;
  logic [7:0]  ids_r,     ids_nxt;
  logic [7:0]  cur_r,     cur_nxt;
  logic [30:0] sstat_r,   sstat_nxt;
  logic [7:0]  scount_r,  scount_nxt;
  logic [2:0]  ferr_r,    ferr_nxt;
  logic        out_valid_r;
  vsp_result_t out_r,     out_nxt;

  logic [7:0]  b;
  logic [31:0] shifted;
  logic [31:0] v_new;
  logic [2:0]  cnt_new;
  logic        fail_pre;
  logic        v_done;
  logic        v_fail;
  logic [31:0] lim;
  logic        over;
  logic [2:0]  v_err;

  assign q_pop     = q_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_r;
  assign b         = q_item.data;

  // Varint byte: place 7 payload bits at the current group (4 on the last)
  always_comb begin
    case (vcnt_r)
      3'd0:    shifted = {25'd0, b[6:0]};
      3'd1:    shifted = {18'd0, b[6:0], 7'd0};
      3'd2:    shifted = {11'd0, b[6:0], 14'd0};
      3'd3:    shifted = {4'd0, b[6:0], 21'd0};
      default: shifted = {b[3:0], 28'd0};
    endcase
    v_new    = vval_r | shifted;
    cnt_new  = vcnt_r + 3'd1;
    fail_pre = (vcnt_r >= VARINT_MAX_BYTES) ||
               ((vcnt_r == VARINT_MAX_BYTES - 3'd1) && (b[7:4] != 4'd0));
    v_done   = !fail_pre && !b[7];
    v_fail   = fail_pre || (b[7] && (cnt_new >= VARINT_MAX_BYTES));
  end

  // Field limit and error code by phase
  always_comb begin
    unique case (phase_r) inside
      PH_STATUS: begin
        lim   = 32'h7fff_ffff;
        v_err = ERR_STATUS;
      end
      PH_NAME_LEN: begin
        lim   = {16'd0, cfg.max_name_len};
        v_err = ERR_NAME;
      end
      PH_ID_LEN: begin
        lim   = {16'd0, cfg.max_id_len};
        v_err = ERR_ID;
      end
      default: begin
        lim   = {24'd0, cfg.max_id_count};
        v_err = ERR_COUNT;
      end
    endcase
    over = (v_new > lim);
  end

  always_comb begin
    phase_nxt  = phase_r;
    vval_nxt   = vval_r;
    vcnt_nxt   = vcnt_r;
    left_nxt   = left_r;
    ids_nxt    = ids_r;
    cur_nxt    = cur_r;
    sstat_nxt  = sstat_r;
    scount_nxt = scount_r;
    ferr_nxt   = ferr_r;
    out_nxt    = '0;
    out_nxt.kind = KIND_HEADER;

    if (q_item.is_end) begin
      out_nxt.kind         = KIND_VERDICT;
      out_nxt.status_value = sstat_r;
      out_nxt.id_total     = scount_r;
      out_nxt.error_code   = ferr_r;
      if (ferr_r == ERR_NONE) begin
        unique case (phase_r) inside
          PH_STATUS:            out_nxt.error_code = ERR_STATUS;
          PH_NAME_LEN, PH_NAME: out_nxt.error_code = ERR_NAME;
          PH_COUNT:             out_nxt.error_code = ERR_COUNT;
          PH_ID_LEN, PH_ID:     out_nxt.error_code = ERR_ID;
          default: out_nxt.error_code = q_item.trunc ? ERR_TRUNC : ERR_NONE;
        endcase
      end
      out_nxt.complete = (out_nxt.error_code == ERR_NONE);
      // Back to the start of a message
      phase_nxt  = PH_STATUS;
      vval_nxt   = '0;
      vcnt_nxt   = '0;
      left_nxt   = '0;
      ids_nxt    = '0;
      cur_nxt    = '0;
      sstat_nxt  = '0;
      scount_nxt = '0;
      ferr_nxt   = ERR_NONE;
    end else if (ferr_r == ERR_NONE) begin
      unique case (phase_r)
        PH_NAME: begin
          out_nxt.kind     = KIND_NAME;
          out_nxt.out_byte = b;
          left_nxt         = left_r - 16'd1;
          if (left_r == 16'd1) phase_nxt = PH_AFTER_NAME;
        end
        PH_ID: begin
          out_nxt.kind     = KIND_ID;
          out_nxt.out_byte = b;
          out_nxt.id_index = cur_r;
          left_nxt         = left_r - 16'd1;
          if (left_r == 16'd1) begin
            ids_nxt   = ids_r - 8'd1;
            cur_nxt   = cur_r + 8'd1;
            phase_nxt = (ids_r == 8'd1) ? PH_DONE : PH_ID_LEN;
          end
        end
        PH_DONE: ferr_nxt = ERR_TRAILING;
        default: begin
          // Varint phases; after the name, only status one may go on
          if (phase_r == PH_AFTER_NAME && sstat_r != 31'd1) begin
            ferr_nxt = ERR_TRAILING;
          end else if (v_fail || (v_done && over)) begin
            ferr_nxt = v_err;
          end else if (v_done) begin
            vval_nxt = '0;
            vcnt_nxt = '0;
            unique case (phase_r) inside
              PH_STATUS: begin
                sstat_nxt = v_new[30:0];
                phase_nxt = PH_NAME_LEN;
              end
              PH_NAME_LEN: begin
                left_nxt  = v_new[15:0];
                phase_nxt = (v_new[15:0] != 16'd0) ? PH_NAME : PH_AFTER_NAME;
              end
              PH_ID_LEN: begin
                left_nxt = v_new[15:0];
                if (v_new[15:0] != 16'd0) begin
                  phase_nxt = PH_ID;
                end else begin
                  ids_nxt   = ids_r - 8'd1;
                  cur_nxt   = cur_r + 8'd1;
                  phase_nxt = (ids_r == 8'd1) ? PH_DONE : PH_ID_LEN;
                end
              end
              default: begin
                scount_nxt = v_new[7:0];
                ids_nxt    = v_new[7:0];
                cur_nxt    = '0;
                phase_nxt  = (v_new[7:0] == 8'd0) ? PH_DONE : PH_ID_LEN;
              end
            endcase
          end else begin
            vval_nxt = v_new;
            vcnt_nxt = cnt_new;
            if (phase_r == PH_AFTER_NAME) phase_nxt = PH_COUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STATUS;
      vval_r      <= '0;
      vcnt_r      <= '0;
      left_r      <= '0;
      ids_r       <= '0;
      cur_r       <= '0;
      sstat_r     <= '0;
      scount_r    <= '0;
      ferr_r      <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r  <= phase_nxt;
        vval_r   <= vval_nxt;
        vcnt_r   <= vcnt_nxt;
        left_r   <= left_nxt;
        ids_r    <= ids_nxt;
        cur_r    <= cur_nxt;
        sstat_r  <= sstat_nxt;
        scount_r <= scount_nxt;
        ferr_r   <= ferr_nxt;
      end
      if (q_pop) out_valid_r <= 1'b1;
      else if (res_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_r <= out_nxt;
  end

  `VSP_ASSERT_NOW(a_string_nonempty, phase_r == PH_NAME || phase_r == PH_ID, left_r != 16'd0, "string phase with zero bytes left")
  `VSP_ASSERT_NOW(a_varint_len, ferr_r == ERR_NONE, vcnt_r < VARINT_MAX_BYTES, "varint byte count past limit")
  `VSP_ASSERT_NOW(a_verdict_flag, out_valid_r && out_r.kind == KIND_VERDICT, out_r.complete == (out_r.error_code == ERR_NONE), "complete flag disagrees with error")
  `VSP_ASSERT_NEXT(a_err_sticky, ferr_r != ERR_NONE && !(q_pop && q_item.is_end), ferr_r == $past(ferr_r), "first error overwritten")

endmodule
